[rtl/jlpg_pkg.sv]
// Shared types, register codes and saturating helpers for the jerk limited
// profile generator. No dependencies; every other file uses it by scoped name.
package jlpg_pkg;

  // One request: start state of the motion and how many points to emit.
  typedef struct packed {
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] start_acc;
    logic        [6:0]  num_points;
  } in_t;

  // One trajectory point.
  typedef struct packed {
    logic signed [31:0] position;
    logic signed [31:0] final_vel;
    logic signed [31:0] final_acc;
    logic               last;
  } out_t;

  // Register file contents as seen by the datapath.
  typedef struct packed {
    logic [16:0] step_time;
    logic [30:0] inv_step_time;
    logic [30:0] speed_target;
    logic [30:0] accel_limit;
    logic [30:0] jerk_limit;
  } cfg_t;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_STEP_TIME = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_TARGET  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JERK_LIMIT    = 3'd4;

  localparam logic [16:0] RST_STEP_TIME     = 17'd1311;
  localparam logic [30:0] RST_INV_STEP_TIME = 31'd3276800;
  localparam logic [30:0] RST_SPEED_TARGET  = 31'd1441792;
  localparam logic [30:0] RST_ACCEL_LIMIT   = 31'd655360;
  localparam logic [30:0] RST_JERK_LIMIT    = 31'd655360;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // Signed 32 bit add that saturates instead of wrapping.
  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? Q_MIN : Q_MAX;
    end
    return s[31:0];
  endfunction

  // Signed 32 bit subtract that saturates instead of wrapping.
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = {a[31], a} - {b[31], b};
    if (s[32] != s[31]) begin
      return s[32] ? Q_MIN : Q_MAX;
    end
    return s[31:0];
  endfunction

  // Clamp to the symmetric range [-lim, +lim].
  function automatic logic signed [31:0] clamp_sym(input logic signed [31:0] x,
                                                   input logic [30:0] lim);
    logic signed [32:0] xl;
    logic signed [32:0] pl;
    logic signed [32:0] nl;
    xl = {x[31], x};
    pl = {2'b00, lim};
    nl = -pl;
    if (xl > pl) begin
      return pl[31:0];
    end
    if (xl < nl) begin
      return nl[31:0];
    end
    return x;
  endfunction

  // True when x lies outside [-lim, +lim].
  function automatic logic over_sym(input logic signed [31:0] x,
                                    input logic [30:0] lim);
    logic signed [32:0] xl;
    logic signed [32:0] pl;
    xl = {x[31], x};
    pl = {2'b00, lim};
    return (xl > pl) || (xl < -pl);
  endfunction

endpackage

[rtl/jerk_limited_profile_generator.sv]
// Jerk limited velocity profile generator, signed Q16.16.
//
// Input channel (in_valid / in_stall / in_data): one transaction carries a
// start position, speed, acceleration and a point count. The block raises
// in_stall for as long as it works on a request. A count of zero produces
// no output; a count above MAX_POINTS is cut to MAX_POINTS.
// Output channel (out_valid / out_stall / out_data): one transaction per
// trajectory point, in order. The final point has last set and carries the
// final speed and acceleration; on other points those fields are zero.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always
// ready; writes are meant to happen while the block is idle. Indexes past
// the register list are dropped.
// Datapath: all products go through one shared two-stage multiplier under a
// sequencer. Each point walks the states MV to UJ, plus MK to UK when the
// jerk limit kicks in and the acceleration has to be recomputed, then EMIT.
// A stalled receiver holds the output register; the sequencer keeps working
// on the next point and waits only when that point is ready to be stored.
// Reset (rst, synchronous) returns the sequencer to idle, drops any pending
// output and restores the configuration registers to their defaults.
module jerk_limited_profile_generator #(
  parameter int MAX_POINTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  jlpg_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output jlpg_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jlpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int NW = $bits(in_data.num_points);
  localparam logic [31:0] MAXP = 32'(MAX_POINTS);

  // Sequencer codes. Each point walks MV .. UJ, optionally MK .. UK, then EMIT.
  localparam logic [4:0] ST_IDLE = 5'd0;   // waiting for a request
  localparam logic [4:0] ST_MV   = 5'd1;   // issue v * dt
  localparam logic [4:0] ST_MA   = 5'd2;   // issue a * dt
  localparam logic [4:0] ST_UX   = 5'd3;   // x += v * dt
  localparam logic [4:0] ST_UV   = 5'd4;   // v += a * dt
  localparam logic [4:0] ST_DT   = 5'd5;   // form target - v
  localparam logic [4:0] ST_MT   = 5'd6;   // issue (target - v) / dt
  localparam logic [4:0] ST_WT   = 5'd7;
  localparam logic [4:0] ST_UA   = 5'd8;   // a2 = clamp to accel limit
  localparam logic [4:0] ST_DJ   = 5'd9;   // form a2 - a
  localparam logic [4:0] ST_MJ   = 5'd10;  // issue (a2 - a) / dt
  localparam logic [4:0] ST_WJ   = 5'd11;
  localparam logic [4:0] ST_UJ   = 5'd12;  // check jerk against its limit
  localparam logic [4:0] ST_MK   = 5'd13;  // issue jerk * dt
  localparam logic [4:0] ST_WK   = 5'd14;
  localparam logic [4:0] ST_UK   = 5'd15;  // a = clamp(a + jerk * dt)
  localparam logic [4:0] ST_EMIT = 5'd16;  // hand the point to the output

  jlpg_pkg::cfg_t regs;

  logic [4:0]         state;
  logic [CW-1:0]      remaining;
  logic signed [31:0] x;
  logic signed [31:0] v;
  logic signed [31:0] a;
  logic signed [31:0] a2;
  logic signed [31:0] opnd;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [31:0] mul_res;
  logic               in_accept;
  logic               out_free;
  logic [31:0]        n_ext;
  logic [31:0]        n_clip;

  jlpg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // Operand selection for the shared multiplier. The result shows up in
  // mul_res after passing the product and result registers of jlpg_qmul.
  always_comb begin
    case (state)
      ST_MV:   mul_a = v;
      ST_MA:   mul_a = a;
      default: mul_a = opnd;
    endcase
    case (state) inside
      ST_MT, ST_MJ: mul_b = {1'b0, regs.inv_step_time};
      default:      mul_b = {15'd0, regs.step_time};
    endcase
  end

  jlpg_qmul u_qmul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .res  (mul_res)
  );

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    n_ext  = {{(32 - NW){1'b0}}, in_data.num_points};
    n_clip = (n_ext > MAXP) ? MAXP : n_ext;
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept && (n_clip != 32'd0)) begin
            state <= ST_MV;
          end
        end
        ST_MV: state <= ST_MA;
        ST_MA: state <= ST_UX;
        ST_UX: state <= ST_UV;
        ST_UV: state <= ST_DT;
        ST_DT: state <= ST_MT;
        ST_MT: state <= ST_WT;
        ST_WT: state <= ST_UA;
        ST_UA: state <= ST_DJ;
        ST_DJ: state <= ST_MJ;
        ST_MJ: state <= ST_WJ;
        ST_WJ: state <= ST_UJ;
        ST_UJ: begin
          if (jlpg_pkg::over_sym(mul_res, regs.jerk_limit)) begin
            state <= ST_MK;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_MK: state <= ST_WK;
        ST_WK: state <= ST_UK;
        ST_UK: state <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            state <= (remaining == CW'(1)) ? ST_IDLE : ST_MV;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          x         <= in_data.start_pos;
          v         <= in_data.start_vel;
          a         <= in_data.start_acc;
          remaining <= n_clip[CW-1:0];
        end
      end
      ST_UX: x <= jlpg_pkg::sat_add(x, mul_res);
      ST_UV: v <= jlpg_pkg::sat_add(v, mul_res);
      ST_DT: opnd <= jlpg_pkg::sat_sub({1'b0, regs.speed_target}, v);
      ST_UA: a2 <= jlpg_pkg::clamp_sym(mul_res, regs.accel_limit);
      ST_DJ: opnd <= jlpg_pkg::sat_sub(a2, a);
      ST_UJ: begin
        // Within the jerk limit the new acceleration a2 is taken as is;
        // otherwise the clamped jerk is kept for the recompute.
        if (jlpg_pkg::over_sym(mul_res, regs.jerk_limit)) begin
          opnd <= jlpg_pkg::clamp_sym(mul_res, regs.jerk_limit);
        end else begin
          a <= a2;
        end
      end
      ST_UK: a <= jlpg_pkg::clamp_sym(jlpg_pkg::sat_add(a, mul_res), regs.accel_limit);
      ST_EMIT: begin
        if (out_free) begin
          remaining <= remaining - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register: loaded from EMIT, held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      out_data.position <= x;
      out_data.last     <= (remaining == CW'(1));
      if (remaining == CW'(1)) begin
        out_data.final_vel <= v;
        out_data.final_acc <= a;
      end else begin
        out_data.final_vel <= '0;
        out_data.final_acc <= '0;
      end
    end
  end

endmodule

[rtl/jlpg_cfg.sv]
// Configuration register file of the profile generator.
// Depends on jlpg_pkg for the register codes, reset values and cfg_t.
module jlpg_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [jlpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output jlpg_pkg::cfg_t                 regs
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.step_time     <= jlpg_pkg::RST_STEP_TIME;
      regs.inv_step_time <= jlpg_pkg::RST_INV_STEP_TIME;
      regs.speed_target  <= jlpg_pkg::RST_SPEED_TARGET;
      regs.accel_limit   <= jlpg_pkg::RST_ACCEL_LIMIT;
      regs.jerk_limit    <= jlpg_pkg::RST_JERK_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jlpg_pkg::REG_STEP_TIME:     regs.step_time     <= cfg_data[16:0];
        jlpg_pkg::REG_INV_STEP_TIME: regs.inv_step_time <= cfg_data[30:0];
        jlpg_pkg::REG_SPEED_TARGET:  regs.speed_target  <= cfg_data[30:0];
        jlpg_pkg::REG_ACCEL_LIMIT:   regs.accel_limit   <= cfg_data[30:0];
        jlpg_pkg::REG_JERK_LIMIT:    regs.jerk_limit    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/jlpg_qmul.sv]
// Shared Q16.16 multiplier: registered 32x32 product, then round to nearest
// (ties away from zero), saturate and register the result.
module jlpg_qmul (
  input  logic               clk,
  input  logic signed [31:0] op_a,
  input  logic signed [31:0] op_b,
  output logic signed [31:0] res
);

  logic signed [63:0] prod;
  logic               neg;
  logic        [63:0] mag;
  logic        [63:0] rnd;
  logic        [47:0] q;
  logic signed [31:0] res_next;

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  always_comb begin
    neg = prod[63];
    mag = neg ? 64'(-prod) : 64'(prod);
    rnd = mag + 64'd32768;
    q   = rnd[63:16];
    if (!neg) begin
      res_next = (q > 48'h0000_7FFF_FFFF) ? jlpg_pkg::Q_MAX : q[31:0];
    end else begin
      res_next = (q > 48'h0000_8000_0000) ? jlpg_pkg::Q_MIN : -q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

[rtl/jlpg_checker.sv]
// Port level checks for the profile generator, attached by bind below.
// Depends on jlpg_pkg for the channel payload types.
module jlpg_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input jlpg_pkg::in_t                  in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input jlpg_pkg::out_t                 out_data,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);

  // Reset leaves the block idle with nothing to deliver.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("block not idle after reset");

  // A request with points keeps the input side busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (in_data.num_points != 7'd0)) |=> in_stall)
    else $error("input not stalled while a request is running");

  // Only the final point carries speed and acceleration.
  a_final_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.last) |->
      (out_data.final_vel == 32'sd0 && out_data.final_acc == 32'sd0))
    else $error("final fields set on a point that is not the last");

  // A stalled output transaction holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output changed");

  // The config channel never holds off a write.
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write not taken");

endmodule

bind jerk_limited_profile_generator jlpg_checker u_jlpg_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);
